### sv/annexb_pkg.sv
// ----------------------------------------------------------------------------
// annexb_pkg
// Shared widths, NAL type codes and the close-event record of the splitter.
// ----------------------------------------------------------------------------
package annexb_pkg;

  localparam int unsigned POS_BITS   = 24;
  localparam int unsigned FIELD_W    = 24;
  localparam int unsigned TYPE_W     = 6;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [TYPE_W-1:0] H264_SPS = TYPE_W'(7);
  localparam logic [TYPE_W-1:0] H264_PPS = TYPE_W'(8);
  localparam logic [TYPE_W-1:0] HEVC_VPS = TYPE_W'(32);
  localparam logic [TYPE_W-1:0] HEVC_SPS = TYPE_W'(33);
  localparam logic [TYPE_W-1:0] HEVC_PPS = TYPE_W'(34);

  localparam int unsigned SEEN_VPS = 0;
  localparam int unsigned SEEN_SPS = 1;
  localparam int unsigned SEEN_PPS = 2;

  typedef struct packed {
    logic               valid;
    logic               key;
    logic [7:0]         first_byte;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] length;
  } close_t;

  typedef struct packed {
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] length;
    logic [TYPE_W-1:0]  nal_type;
    logic               keep;
    logic               params_ready;
  } desc_t;

endpackage

### sv/annexb_byte_if.sv
// ----------------------------------------------------------------------------
// annexb_byte_if
// Byte word channel: one frame byte with its keyframe and last-byte flags.
// ----------------------------------------------------------------------------
interface annexb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_keyframe;
  logic       frame_last;

  modport source (output valid, data_byte, frame_keyframe, frame_last, input ready);
  modport sink   (input valid, data_byte, frame_keyframe, frame_last, output ready);
endinterface

### sv/annexb_nal_if.sv
// ----------------------------------------------------------------------------
// annexb_nal_if
// Descriptor word channel: one NAL unit descriptor per word.
// ----------------------------------------------------------------------------
interface annexb_nal_if;
  logic        valid;
  logic        ready;
  logic [23:0] nal_offset;
  logic [23:0] nal_length;
  logic [5:0]  nal_type;
  logic        keep;
  logic        params_ready;

  modport source (output valid, nal_offset, nal_length, nal_type, keep, params_ready,
                  input ready);
  modport sink   (input valid, nal_offset, nal_length, nal_type, keep, params_ready,
                  output ready);
endinterface

### sv/annexb_scan.sv
// ----------------------------------------------------------------------------
// annexb_scan
// Input register and start-code scanner; tracks the open NAL unit and emits a
// close event when a unit ends at a start code or at the frame's last byte.
// ----------------------------------------------------------------------------
module annexb_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  annexb_byte_if.sink        byte_i,
  input  logic               space_i,
  output annexb_pkg::close_t close_o
);
  import annexb_pkg::*;

  logic                v_q;
  logic [7:0]          b_q;
  logic                key_q;
  logic                last_q;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [1:0]          zrun_q, zrun_d;
  logic                inside_q, inside_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic [POS_BITS-1:0] endnz_q, endnz_d;
  logic [7:0]          fb_q, fb_d;
  logic                fbt_q, fbt_d;

  logic                adv;
  logic                sc;
  logic [POS_BITS-1:0] npos;
  logic [POS_BITS-1:0] end_upd;
  logic [POS_BITS-1:0] c_end;
  logic [7:0]          c_fb;

  assign adv          = v_q && space_i;
  assign byte_i.ready = !v_q || space_i;

  assign npos    = (pos_q == POS_MAX) ? pos_q : pos_q + POS_BITS'(1);
  assign sc      = (b_q == 8'd1) && zrun_q[1];
  assign end_upd = (inside_q && (b_q != 8'd0)) ? npos : endnz_q;
  assign c_end   = sc ? endnz_q : end_upd;
  assign c_fb    = (sc || fbt_q) ? fb_q : b_q;

  always_comb begin
    close_o.valid      = adv && (sc || last_q) && inside_q && (c_end > start_q);
    close_o.key        = key_q;
    close_o.first_byte = c_fb;
    close_o.offset     = FIELD_W'(start_q);
    close_o.length     = FIELD_W'(c_end - start_q);
  end

  always_comb begin
    pos_d    = npos;
    zrun_d   = (b_q != 8'd0) ? 2'd0 : ((zrun_q == 2'd3) ? zrun_q : zrun_q + 2'd1);
    inside_d = inside_q;
    start_d  = start_q;
    endnz_d  = endnz_q;
    fb_d     = fb_q;
    fbt_d    = fbt_q;
    if (last_q) begin
      pos_d    = '0;
      zrun_d   = '0;
      inside_d = 1'b0;
      start_d  = '0;
      endnz_d  = '0;
      fb_d     = '0;
      fbt_d    = 1'b0;
    end else if (sc) begin
      inside_d = 1'b1;
      start_d  = npos;
      endnz_d  = npos;
      fb_d     = '0;
      fbt_d    = 1'b0;
    end else if (inside_q) begin
      endnz_d = end_upd;
      fb_d    = c_fb;
      fbt_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= 1'b0;
      pos_q    <= '0;
      zrun_q   <= '0;
      inside_q <= 1'b0;
      start_q  <= '0;
      endnz_q  <= '0;
      fb_q     <= '0;
      fbt_q    <= 1'b0;
    end else begin
      if (byte_i.ready) begin
        v_q <= byte_i.valid;
      end
      if (adv) begin
        pos_q    <= pos_d;
        zrun_q   <= zrun_d;
        inside_q <= inside_d;
        start_q  <= start_d;
        endnz_q  <= endnz_d;
        fb_q     <= fb_d;
        fbt_q    <= fbt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      b_q    <= byte_i.data_byte;
      key_q  <= byte_i.frame_keyframe;
      last_q <= byte_i.frame_last;
    end
  end

  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_q) |=> (pos_q == '0) && !inside_q)
    else $error("frame end did not clear position");

  a_zero_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !last_q && (b_q == 8'd0)) |=> (zrun_q != 2'd0))
    else $error("zero byte not counted");

endmodule

### sv/annexb_desc.sv
// ----------------------------------------------------------------------------
// annexb_desc
// Decodes NAL type and keep flag, latches parameter sets seen on keyframes,
// and queues descriptors in a two-word output buffer.
// ----------------------------------------------------------------------------
module annexb_desc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               codec_hevc_i,
  input  annexb_pkg::close_t close_i,
  output logic               space_o,
  annexb_nal_if.source       nal_o
);
  import annexb_pkg::*;

  desc_t                 fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic [2:0]            seen_q, seen_d;

  logic              push, pop;
  logic [TYPE_W-1:0] ty;
  logic              keep;
  logic              rdy;
  desc_t             ent;
  desc_t             head;

  always_comb begin
    seen_d = seen_q;
    if (codec_hevc_i) begin
      ty   = close_i.first_byte[6:1];
      keep = !((ty == HEVC_VPS) || (ty == HEVC_SPS) || (ty == HEVC_PPS));
      if (close_i.key) begin
        if (ty == HEVC_VPS) seen_d[SEEN_VPS] = 1'b1;
        if (ty == HEVC_SPS) seen_d[SEEN_SPS] = 1'b1;
        if (ty == HEVC_PPS) seen_d[SEEN_PPS] = 1'b1;
      end
      rdy = seen_d[SEEN_VPS] && seen_d[SEEN_SPS] && seen_d[SEEN_PPS];
    end else begin
      ty   = {1'b0, close_i.first_byte[4:0]};
      keep = !((ty == H264_SPS) || (ty == H264_PPS));
      if (close_i.key) begin
        if (ty == H264_SPS) seen_d[SEEN_SPS] = 1'b1;
        if (ty == H264_PPS) seen_d[SEEN_PPS] = 1'b1;
      end
      rdy = seen_d[SEEN_SPS] && seen_d[SEEN_PPS];
    end
  end

  always_comb begin
    ent.offset       = close_i.offset;
    ent.length       = close_i.length;
    ent.nal_type     = ty;
    ent.keep         = keep;
    ent.params_ready = rdy;
  end

  assign push    = close_i.valid;
  assign pop     = nal_o.valid && nal_o.ready;
  assign space_o = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign head    = fifo_q[rd_q];

  assign nal_o.valid        = (cnt_q != '0);
  assign nal_o.nal_offset   = head.offset;
  assign nal_o.nal_length   = head.length;
  assign nal_o.nal_type     = head.nal_type;
  assign nal_o.keep         = head.keep;
  assign nal_o.params_ready = head.params_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      seen_q <= '0;
    end else begin
      if (push) begin
        wr_q   <= wr_q + FIFO_PTR_W'(1);
        seen_q <= seen_d;
      end
      if (pop) begin
        rd_q <= rd_q + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= ent;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("descriptor buffer overflow");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> space_o)
    else $error("descriptor pushed into full buffer");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nal_o.valid |-> (nal_o.nal_length != '0))
    else $error("empty NAL unit reported");

  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((seen_q & $past(seen_q)) == $past(seen_q)))
    else $error("parameter set flag dropped");

endmodule

### sv/annexb_nal_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an Annex-B byte stream into NAL unit descriptors.
//
//   channel   dir   word
//   byte_i    in    data_byte, frame_keyframe, frame_last
//   nal_o     out   nal_offset, nal_length, nal_type, keep, params_ready
//   cfg       in    cfg_we_i / cfg_data_i = codec_hevc
//
// One byte per cycle while the output buffer has room; the byte that closes
// a unit passes the input register, then its descriptor the output buffer.
// A two-word output buffer keeps bytes flowing while a descriptor waits.
// Reset clears the frame state, the parameter set flags and the codec select.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_data_i,
  annexb_byte_if.sink  byte_i,
  annexb_nal_if.source nal_o
);
  import annexb_pkg::*;

  logic   codec_q;
  logic   space;
  close_t close_ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q <= 1'b0;
    end else if (cfg_we_i) begin
      codec_q <= cfg_data_i;
    end
  end

  annexb_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .space_i (space),
    .close_o (close_ev)
  );

  annexb_desc u_desc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .codec_hevc_i (codec_q),
    .close_i      (close_ev),
    .space_o      (space),
    .nal_o        (nal_o)
  );

endmodule

### sim/annexb_nal_unit_splitter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_tb
// Self-checking bench for the Annex-B NAL unit splitter.
//
// Frames are fed byte by byte on the byte channel. A behavioral tracker
// follows start codes, zero trimming and parameter set latching to build
// the descriptor each closed unit must give. A checker compares every
// descriptor word with the oldest pending one. The run covers directed
// frames under both codec rules, randomized frames with broken start codes
// and noise, a long output hold-off, and a final stretch without idling.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter_tb;
  import annexb_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 80;
  localparam int TAIL_CYCLES  = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 40;

  localparam logic [TYPE_W-1:0] H264_SLICE = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] H264_IDR   = TYPE_W'(5);
  localparam logic [TYPE_W-1:0] HEVC_TRAIL = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] HEVC_IDR   = TYPE_W'(19);

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_data_i;

  annexb_byte_if byte_if ();
  annexb_nal_if  nal_if ();

  annexb_nal_unit_splitter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .byte_i     (byte_if),
    .nal_o      (nal_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // tracker state
  logic                hevc_m      = 1'b0;
  logic [POS_BITS-1:0] pos_m       = '0;
  logic [POS_BITS-1:0] start_m     = '0;
  logic [POS_BITS-1:0] end_nz_m    = '0;
  logic [1:0]          zrun_m      = '0;
  logic                in_unit_m   = 1'b0;
  logic [7:0]          first_m     = '0;
  logic                first_got_m = 1'b0;
  logic [2:0]          seen_m      = '0;

  desc_t pending_desc_q[$];

  int  mismatches   = 0;
  int  bytes_sent   = 0;
  int  frames_sent  = 0;
  int  descs_seen   = 0;
  int  param_sets   = 0;
  bit  src_idle_en  = 1'b1;
  bit  sink_idle_en = 1'b1;
  bit  hold_req     = 1'b0;

  function automatic logic [POS_BITS-1:0] step_pos(input logic [POS_BITS-1:0] p);
    return (p == POS_MAX) ? POS_MAX : p + POS_BITS'(1);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic close_nal_unit(input logic key, output logic fired);
    desc_t             d;
    logic [TYPE_W-1:0] ty;
    fired = 1'b0;
    if (in_unit_m && end_nz_m > start_m) begin
      fired = 1'b1;
      if (hevc_m) begin
        ty     = first_m[6:1];
        d.keep = !(ty == HEVC_VPS || ty == HEVC_SPS || ty == HEVC_PPS);
        if (key) begin
          if (ty == HEVC_VPS) seen_m[SEEN_VPS] = 1'b1;
          if (ty == HEVC_SPS) seen_m[SEEN_SPS] = 1'b1;
          if (ty == HEVC_PPS) seen_m[SEEN_PPS] = 1'b1;
        end
        d.params_ready = &seen_m;
      end else begin
        ty     = {1'b0, first_m[4:0]};
        d.keep = !(ty == H264_SPS || ty == H264_PPS);
        if (key) begin
          if (ty == H264_SPS) seen_m[SEEN_SPS] = 1'b1;
          if (ty == H264_PPS) seen_m[SEEN_PPS] = 1'b1;
        end
        d.params_ready = seen_m[SEEN_SPS] & seen_m[SEEN_PPS];
      end
      d.offset   = FIELD_W'(start_m);
      d.length   = FIELD_W'(end_nz_m - start_m);
      d.nal_type = ty;
      pending_desc_q.insert(pending_desc_q.size(), d);
      if (!d.keep) param_sets++;
    end
  endtask

  task automatic track_byte(input logic [7:0] b, input logic key, input logic last);
    logic                fired;
    logic [POS_BITS-1:0] p;
    fired = 1'b0;
    p     = pos_m;
    if (b == 8'h01 && zrun_m >= 2) begin
      close_nal_unit(key, fired);
      in_unit_m   = 1'b1;
      start_m     = step_pos(p);
      end_nz_m    = start_m;
      first_m     = '0;
      first_got_m = 1'b0;
    end else if (in_unit_m) begin
      if (!first_got_m) begin
        first_m     = b;
        first_got_m = 1'b1;
      end
      if (b != 8'h00) end_nz_m = step_pos(p);
    end
    if (b == 8'h00) zrun_m = (zrun_m == 2'd3) ? 2'd3 : zrun_m + 2'd1;
    else zrun_m = '0;
    pos_m = step_pos(p);
    if (last) begin
      if (!fired) close_nal_unit(key, fired);
      pos_m       = '0;
      zrun_m      = '0;
      in_unit_m   = 1'b0;
      start_m     = '0;
      end_nz_m    = '0;
      first_m     = '0;
      first_got_m = 1'b0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic key, input logic last);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    byte_if.valid          <= 1'b1;
    byte_if.data_byte      <= b;
    byte_if.frame_keyframe <= key;
    byte_if.frame_last     <= last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    bytes_sent++;
    track_byte(b, key, last);
  endtask

  task automatic send_frame(input logic [7:0] fq[$], input logic key);
    for (int i = 0; i < fq.size(); i++) send_byte(fq[i], key, i == fq.size() - 1);
    frames_sent++;
  endtask

  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_desc_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_codec(input logic hevc);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= hevc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hevc_m = hevc;
  endtask

  function automatic logic [7:0] nal_header();
    logic [TYPE_W-1:0] ty;
    logic [7:0]        hb;
    hb = 8'($urandom);
    if ($urandom_range(0, 4) == 0) return hb;
    if (hevc_m) begin
      case ($urandom_range(0, 5))
        0:       ty = HEVC_VPS;
        1:       ty = HEVC_SPS;
        2:       ty = HEVC_PPS;
        3:       ty = HEVC_IDR;
        4:       ty = HEVC_TRAIL;
        default: ty = TYPE_W'($urandom);
      endcase
      return {1'b0, ty, hb[0]};
    end
    case ($urandom_range(0, 4))
      0:       ty = H264_SPS;
      1:       ty = H264_PPS;
      2:       ty = H264_IDR;
      3:       ty = H264_SLICE;
      default: ty = TYPE_W'($urandom);
    endcase
    return {1'b0, hb[6:5], ty[4:0]};
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0, 1:    return 8'h00;
      2:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_frame();
    logic [7:0] fq[$];
    logic       key;
    key = ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) fq.insert(fq.size(), noise_byte());
    end else begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) fq.insert(fq.size(), 8'($urandom));
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) == 0) fq.insert(fq.size(), 8'h00);
        fq.insert(fq.size(), 8'h00);
        fq.insert(fq.size(), 8'h00);
        fq.insert(fq.size(), ($urandom_range(0, 15) == 0) ? 8'h02 : 8'h01);
        fq.insert(fq.size(), nal_header());
        repeat ($urandom_range(0, 8))
          fq.insert(fq.size(), ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) fq.insert(fq.size(), 8'h00);
      end
      if ($urandom_range(0, 7) == 0) begin
        fq.insert(fq.size(), 8'h00);
        fq.insert(fq.size(), 8'h00);
        fq.insert(fq.size(), 8'h01);
      end
    end
    send_frame(fq, key);
  endtask

  task automatic run_random_frames(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) send_random_frame();
    wait_drained();
  endtask

  task automatic test_h264_directed();
    logic [7:0] fq[$];
    fq = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h00, 8'h01,
           8'h68, 8'h00, 8'h00, 8'h01};
    send_frame(fq, 1'b0);
    fq = '{8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
           8'h01, 8'h68, 8'hFF, 8'h00};
    send_frame(fq, 1'b1);
    wait_drained();
  endtask

  task automatic test_hevc_directed();
    logic [7:0] fq[$];
    set_codec(1'b1);
    fq = '{8'h00, 8'h00, 8'h01, 8'h40, 8'h01};
    send_frame(fq, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_mix();
    run_random_frames(300);
    set_codec(1'b0);
    run_random_frames(300);
  endtask

  task automatic test_output_backpressure();
    logic [7:0] fq[$];
    repeat (30) begin
      fq.insert(fq.size(), 8'h00);
      fq.insert(fq.size(), 8'h00);
      fq.insert(fq.size(), 8'h01);
      fq.insert(fq.size(), nal_header() | 8'h01);
      fq.insert(fq.size(), 8'($urandom_range(1, 255)));
    end
    hold_req = 1'b1;
    send_frame(fq, 1'b0);
    wait_drained();
  endtask

  task automatic test_steady_stream();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_codec(1'b1);
    run_random_frames(150);
    set_codec(1'b0);
    run_random_frames(120);
  endtask

  initial begin : nal_sink
    nal_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        nal_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        nal_if.ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(posedge clk_i);
      end else begin
        nal_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : nal_check
    desc_t got;
    desc_t want;
    string bad;
    if (rst_ni === 1'b1 && nal_if.valid === 1'b1 && nal_if.ready === 1'b1) begin
      got.offset       = nal_if.nal_offset;
      got.length       = nal_if.nal_length;
      got.nal_type     = nal_if.nal_type;
      got.keep         = nal_if.keep;
      got.params_ready = nal_if.params_ready;
      if (pending_desc_q.size() == 0) begin
        report_mismatch($sformatf("descriptor %0d with none pending: off=%0d len=%0d",
                                  descs_seen, got.offset, got.length));
      end else begin
        want = pending_desc_q.pop_front();
        bad  = "";
        if (got.offset !== want.offset) bad = {bad, " offset"};
        if (got.length !== want.length) bad = {bad, " length"};
        if (got.nal_type !== want.nal_type) bad = {bad, " type"};
        if (got.keep !== want.keep) bad = {bad, " keep"};
        if (got.params_ready !== want.params_ready) bad = {bad, " params_ready"};
        if (bad != "") begin
          report_mismatch($sformatf(
            "descriptor %0d [%s ] got %0d/%0d/%0d/%b/%b want %0d/%0d/%0d/%b/%b",
            descs_seen, bad, got.offset, got.length, got.nal_type, got.keep,
            got.params_ready, want.offset, want.length, want.nal_type, want.keep,
            want.params_ready));
        end
      end
      descs_seen++;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((byte_if.valid === 1'b1 && byte_if.ready === 1'b1) ||
          (nal_if.valid === 1'b1 && nal_if.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d descriptors pending",
                 STALL_LIMIT, pending_desc_q.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : main
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_data_i             = 1'b0;
    byte_if.valid          = 1'b0;
    byte_if.data_byte      = '0;
    byte_if.frame_keyframe = 1'b0;
    byte_if.frame_last     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_h264_directed();
    test_hevc_directed();
    test_random_mix();
    test_output_backpressure();
    test_steady_stream();

    $display("Summary: %0d bytes in %0d frames, %0d descriptors checked, %0d parameter sets",
             bytes_sent, frames_sent, descs_seen, param_sets);
    $display("Summary: H.264 and HEVC rules, random idling, one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
